FILE: rtl/core/dgd_pkg.sv
`default_nettype none

package dgd_pkg;

  localparam int ACC_W       = 40;
  localparam int FRAC_W      = 14;
  localparam int COEF_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int NFILT       = 8;
  localparam int FILT_IDX_W  = $clog2(NFILT);
  localparam int GRP_IDX_W   = FILT_IDX_W - 1;
  localparam int KEY_W       = 2 * GRP_IDX_W;
  localparam int POW_W       = 48;
  localparam int CFG_IDX_W   = 4;

  localparam int CHUNK_W     = 16;
  localparam int NCHUNK      = (ACC_W + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_CNT_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int MAC_A_W     = ACC_W + COEF_W;
  localparam int PW          = 2 * ACC_W + FRAC_W + 2;
  localparam int REP_SHIFT   = FRAC_W + 2 * ACC_W - POW_W;

  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = KEY_W + 2 * POW_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NFILT] = '{
    16'sd27983, 16'sd26957, 16'sd25701, 16'sd24219,
    16'sd19073, 16'sd16325, 16'sd13080, 16'sd9317
  };

  typedef struct packed {
    logic signed [ACC_W-1:0]  q1;
    logic signed [ACC_W-1:0]  q2;
    logic signed [COEF_W-1:0] coef;
  } cell_t;

  typedef struct packed {
    logic                  start;
    logic [FILT_IDX_W-1:0] idx;
  } pwr_cmd_t;

  typedef struct packed {
    logic                 done;
    logic                 row_fnd;
    logic                 col_fnd;
    logic [GRP_IDX_W-1:0] row_idx;
    logic [GRP_IDX_W-1:0] col_idx;
    logic [POW_W-1:0]     row_pow;
    logic [POW_W-1:0]     col_pow;
  } pwr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dgd_cell.sv
`default_nettype none

module dgd_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  dgd_pkg::cell_t                       nxt,
  input  logic                                 wr_en,
  input  logic signed [dgd_pkg::COEF_W-1:0]    wr_coef,
  input  logic signed [dgd_pkg::COEF_W-1:0]    coef_init,
  output dgd_pkg::cell_t                       cur
);
  import dgd_pkg::*;

  cell_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.q1   <= '0;
      data_r.q2   <= '0;
      data_r.coef <= coef_init;
    end else if (shift_en) begin
      data_r <= nxt;
    end else if (wr_en) begin
      data_r.coef <= wr_coef;
    end
  end

  assign cur = data_r;

endmodule

`default_nettype wire

FILE: rtl/core/dgd_power.sv
`default_nettype none

module dgd_power (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dgd_pkg::pwr_cmd_t                    cmd,
  input  logic signed [dgd_pkg::ACC_W-1:0]     q1,
  input  logic signed [dgd_pkg::ACC_W-1:0]     q2,
  input  logic signed [dgd_pkg::MAC_A_W-1:0]   cq1,
  output dgd_pkg::pwr_stat_t                   stat
);
  import dgd_pkg::*;

  localparam logic [1:0] TERM_Q1    = 2'd0;
  localparam logic [1:0] TERM_Q2    = 2'd1;
  localparam logic [1:0] TERM_CROSS = 2'd2;

  localparam int QX_W   = NCHUNK * CHUNK_W;
  localparam int LOG_CH = $clog2(CHUNK_W);
  localparam int SH_W   = CHUNK_CNT_W + LOG_CH;
  localparam int PROD_W = MAC_A_W + CHUNK_W + 1;
  localparam int REP_W  = PW - 1 - REP_SHIFT;
  localparam logic [CHUNK_CNT_W-1:0] LAST_CHUNK = CHUNK_CNT_W'(NCHUNK - 1);

  logic                         run_r;
  logic                         cmp_r;
  logic [1:0]                   term_r;
  logic [CHUNK_CNT_W-1:0]       chunk_r;
  logic                         row_fnd_r;
  logic                         col_fnd_r;
  logic [GRP_IDX_W-1:0]         row_idx_r;
  logic [GRP_IDX_W-1:0]         col_idx_r;
  logic signed [ACC_W-1:0]      q1_r;
  logic signed [ACC_W-1:0]      q2_r;
  logic signed [MAC_A_W-1:0]    m_r;
  logic [FILT_IDX_W-1:0]        k_r;
  logic signed [PW-1:0]         acc_r;
  logic [PW-2:0]                best_row_r;
  logic [PW-2:0]                best_col_r;

  logic signed [MAC_A_W-1:0]    a_op;
  logic signed [ACC_W-1:0]      q_sel;
  logic [QX_W-1:0]              q_ext;
  logic [SH_W-1:0]              sh_amt;
  logic [CHUNK_W-1:0]           chunk;
  logic signed [CHUNK_W:0]      b_op;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PW-1:0]         prod_ext;
  logic signed [PW-1:0]         term_val;
  logic signed [PW-1:0]         acc_nxt;
  logic [PW-2:0]                pos;
  logic                         last_chunk;
  logic                         row_upd;
  logic                         col_upd;

  function automatic logic [POW_W-1:0] report(input logic [PW-2:0] p);
    logic [REP_W-1:0] r;
    begin
      r = p[PW-2:REP_SHIFT];
      return (|r[REP_W-1:POW_W]) ? '1 : r[POW_W-1:0];
    end
  endfunction

  always_comb begin
    q_sel = (term_r == TERM_Q1) ? q1_r : q2_r;
    case (term_r)
      TERM_Q1: a_op = MAC_A_W'(q1_r) <<< FRAC_W;
      TERM_Q2: a_op = MAC_A_W'(q2_r) <<< FRAC_W;
      default: a_op = m_r;
    endcase
    q_ext      = QX_W'(q_sel);
    last_chunk = (chunk_r == LAST_CHUNK);
    sh_amt     = {chunk_r, {LOG_CH{1'b0}}};
    chunk      = q_ext[sh_amt +: CHUNK_W];
    b_op       = {last_chunk & chunk[CHUNK_W-1], chunk};
    prod       = PROD_W'(a_op) * PROD_W'(b_op);
    prod_ext   = PW'(prod);
    term_val   = prod_ext <<< sh_amt;
    acc_nxt    = (term_r == TERM_CROSS) ? acc_r - term_val : acc_r + term_val;
    pos        = acc_r[PW-1] ? '0 : acc_r[PW-2:0];
    row_upd    = cmp_r && !k_r[FILT_IDX_W-1] && (pos > best_row_r);
    col_upd    = cmp_r && k_r[FILT_IDX_W-1] && (pos > best_col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      cmp_r     <= 1'b0;
      term_r    <= TERM_Q1;
      chunk_r   <= '0;
      row_fnd_r <= 1'b0;
      col_fnd_r <= 1'b0;
      row_idx_r <= '0;
      col_idx_r <= '0;
    end else if (cmd.start) begin
      run_r   <= 1'b1;
      cmp_r   <= 1'b0;
      term_r  <= TERM_Q1;
      chunk_r <= '0;
      if (cmd.idx == '0) begin
        row_fnd_r <= 1'b0;
        col_fnd_r <= 1'b0;
        row_idx_r <= '0;
        col_idx_r <= '0;
      end
    end else if (run_r) begin
      if (last_chunk) begin
        chunk_r <= '0;
        if (term_r == TERM_CROSS) begin
          run_r <= 1'b0;
          cmp_r <= 1'b1;
        end else begin
          term_r <= term_r + 2'd1;
        end
      end else begin
        chunk_r <= chunk_r + 1'b1;
      end
    end else if (cmp_r) begin
      cmp_r <= 1'b0;
      if (row_upd) begin
        row_fnd_r <= 1'b1;
        row_idx_r <= k_r[GRP_IDX_W-1:0];
      end
      if (col_upd) begin
        col_fnd_r <= 1'b1;
        col_idx_r <= k_r[GRP_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q1_r  <= q1;
      q2_r  <= q2;
      m_r   <= cq1;
      k_r   <= cmd.idx;
      acc_r <= '0;
      if (cmd.idx == '0) begin
        best_row_r <= '0;
        best_col_r <= '0;
      end
    end else if (run_r) begin
      acc_r <= acc_nxt;
    end else begin
      if (row_upd) begin
        best_row_r <= pos;
      end
      if (col_upd) begin
        best_col_r <= pos;
      end
    end
  end

  assign stat.done    = cmp_r;
  assign stat.row_fnd = row_fnd_r;
  assign stat.col_fnd = col_fnd_r;
  assign stat.row_idx = row_idx_r;
  assign stat.col_idx = col_idx_r;
  assign stat.row_pow = report(best_row_r);
  assign stat.col_pow = report(best_col_r);

  // The accumulation and the compare never overlap.
  a_run_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(run_r && cmp_r))
    else $error("accumulate and compare active together");

  // A new filter is only started while the unit is free.
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (!run_r && !cmp_r))
    else $error("start while busy");

  // The compare always follows the final accumulate step.
  a_cmp_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmp_r) |-> ($past(run_r) && $past(term_r) == TERM_CROSS))
    else $error("compare without a finished accumulation");

endmodule

`default_nettype wire

FILE: rtl/core/dtmf_goertzel_detector.sv
`default_nettype none

// DTMF detector with eight Goertzel filters held in a ring of eight cells that shifts by one
// cell per clock while a sample is applied, so one 16x40 multiplier updates every filter, and
// the next sample transfer is taken in the last shift for a sample. On the sample marked by
// in_tlast the ring then passes each filter once more through a 56x17 multiply-accumulate
// unit that forms its power chunk by chunk and clears the filters on the way. The result
// waits in an output register; if it has not been taken when the next frame ends, the block
// holds until it is.
module dtmf_goertzel_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dgd_pkg::IN_TDATA_W-1:0]       in_tdata,   // [15:0] sample
  input  logic                                 in_tlast,   // frame_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dgd_pkg::OUT_TDATA_W-1:0]      out_tdata,  // key_code, row_power, col_power, zero pad
  output logic                                 out_tuser,  // tone_found
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dgd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dgd_pkg::COEF_W-1:0]           cfg_data
);
  import dgd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UPD    = 3'd1;
  localparam logic [2:0] ST_PSTART = 3'd2;
  localparam logic [2:0] ST_PWAIT  = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  localparam int W_W = ACC_W + 3;
  localparam logic [FILT_IDX_W-1:0] LAST_FILT = FILT_IDX_W'(NFILT - 1);

  logic [2:0]                   state_r;
  logic [2:0]                   state_nxt;
  logic [FILT_IDX_W-1:0]        cnt_r;
  logic [FILT_IDX_W-1:0]        cnt_nxt;
  logic signed [SAMPLE_W-1:0]   x_r;
  logic                         fe_r;
  logic                         out_valid_r;
  logic [OUT_TDATA_W-1:0]       out_data_r;
  logic                         out_user_r;

  logic                         in_acc;
  logic                         cfg_acc;
  logic                         ring_shift;
  logic                         out_load;
  logic [NFILT-1:0]             coef_wr;
  cell_t                        ring    [NFILT];
  cell_t                        ring_in [NFILT];
  cell_t                        tail;

  logic signed [MAC_A_W-1:0]    prod;
  logic signed [ACC_W+1:0]      fsh;
  logic signed [W_W-1:0]        w;
  logic signed [ACC_W-1:0]      w_sat;
  logic [W_W-ACC_W:0]           w_top;

  pwr_cmd_t                     pwr_cmd;
  pwr_stat_t                    pwr_stat;
  logic [KEY_W-1:0]             key;

  assign in_tready = (state_r == ST_IDLE) ||
                     (state_r == ST_UPD && cnt_r == LAST_FILT && !fe_r);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;

  for (genvar i = 0; i < NFILT; i++) begin : g_cell
    if (i < NFILT - 1) begin : g_mid
      assign ring_in[i] = ring[i+1];
    end else begin : g_end
      assign ring_in[i] = tail;
    end
    assign coef_wr[i] = cfg_acc && (cfg_index == CFG_IDX_W'(i));
    dgd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (ring_shift),
      .nxt       (ring_in[i]),
      .wr_en     (coef_wr[i]),
      .wr_coef   (cfg_data),
      .coef_init (COEF_RESET[i]),
      .cur       (ring[i])
    );
  end

  always_comb begin
    prod  = MAC_A_W'(ring[0].coef) * MAC_A_W'(ring[0].q1);
    fsh   = prod[MAC_A_W-1:FRAC_W];
    w     = W_W'(x_r) + W_W'(fsh) - W_W'(ring[0].q2);
    w_top = w[W_W-1:ACC_W-1];
    if (w_top == '0 || w_top == '1) begin
      w_sat = w[ACC_W-1:0];
    end else if (w[W_W-1]) begin
      w_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
    tail.coef = ring[0].coef;
    if (state_r == ST_UPD) begin
      tail.q1 = w_sat;
      tail.q2 = ring[0].q1;
    end else begin
      tail.q1 = '0;
      tail.q2 = '0;
    end
  end

  assign pwr_cmd.start = (state_r == ST_PSTART);
  assign pwr_cmd.idx   = cnt_r;

  dgd_power u_power (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pwr_cmd),
    .q1    (ring[0].q1),
    .q2    (ring[0].q2),
    .cq1   (prod),
    .stat  (pwr_stat)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ring_shift = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ring_shift = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_FILT) begin
          if (fe_r) begin
            state_nxt = ST_PSTART;
          end else if (!in_acc) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PSTART: begin
        state_nxt = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (pwr_stat.done) begin
          ring_shift = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          state_nxt  = (cnt_r == LAST_FILT) ? ST_OUT : ST_PSTART;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fe_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) begin
        fe_r <= in_tlast;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign key = (pwr_stat.row_fnd && pwr_stat.col_fnd) ?
               {pwr_stat.row_idx, pwr_stat.col_idx} : '0;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_tdata[SAMPLE_W-1:0];
    end
    if (out_load) begin
      out_data_r <= OUT_TDATA_W'({pwr_stat.col_pow, pwr_stat.row_pow, key});
      out_user_r <= pwr_stat.row_fnd && pwr_stat.col_fnd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The ring is aligned, filter 0 at the head, whenever the block is idle.
  a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0))
    else $error("ring not aligned in idle");

  // Finishing the eighth power moves straight to the result load.
  a_last_filter_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PWAIT && pwr_stat.done && cnt_r == LAST_FILT) |=> (state_r == ST_OUT))
    else $error("power phase did not end after the last filter");

  // A result without a tone carries key code zero.
  a_no_tone_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[KEY_W-1:0] == '0))
    else $error("key code set without a tone");

endmodule

`default_nettype wire
